>>> design/sat_pkg.sv
// Package: shared types and constants for the summed-area table block.
`timescale 1ns / 1ps

package sat_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int ELEM_WIDTH = 16;
  localparam int SUM_WIDTH  = 28;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int DIM_W   = 7;
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] MAX_ROWS_D = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] MAX_COLS_D = DIM_W'(MAX_COLS);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_BAD_COORD  = 2'd1;
  localparam logic [1:0] STAT_NOT_LOADED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);

  typedef struct packed {
    logic                         mode;
    logic signed [ELEM_WIDTH-1:0] element_value;
    logic [ROW_W-1:0]             row_first;
    logic [COL_W-1:0]             col_first;
    logic [ROW_W-1:0]             row_final;
    logic [COL_W-1:0]             col_final;
  } sat_in_t;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] sum_value;
    logic [1:0]                  status;
  } sat_out_t;

  // 0 acts as 1, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) res = DIM_W'(1);
    else if (v > maxv) res = maxv;
    return res;
  endfunction

endpackage

>>> design/summed_area_table_rect_query.sv
// Summed-area table builder with rectangle-sum queries, table in a 1W2R memory.
// Load word: the entry above is read on accept; ST_LOAD writes and registers the sum.
// Query word: two rounds of two reads on the read ports, on accept and in ST_QRD; the result
// is registered in ST_QSUM. Only ST_IDLE takes a word; out_ready low stalls ST_LOAD/ST_QSUM.
// Reset (sync, rst_n low) clears load position, running sum and table_complete, sets
// both dimensions to 64; table contents stay undefined, no clearing pass.
`timescale 1ns / 1ps

module summed_area_table_rect_query
  import sat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sat_in_t              in_data,
  // result words
  output logic                 out_valid,
  input  logic                 out_ready,
  output sat_out_t             out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // waiting for a word
    ST_LOAD = 4'b0010,  // above entry is on the read port
    ST_QRD  = 4'b0100,  // first two corners on the read ports
    ST_QSUM = 4'b1000   // last two corners on the read ports
  } state_t;

  state_t state_r, state_nxt;

  // configuration and load bookkeeping
  logic [DIM_W-1:0]     rows_cfg_r, cols_cfg_r;
  logic [DIM_W-1:0]     rows_eff, cols_eff;
  logic [SUM_WIDTH-1:0] row_sum_r;
  logic [ROW_W-1:0]     load_row_r;
  logic [COL_W-1:0]     load_col_r;
  logic                 complete_r;

  // per-word working registers
  logic [SUM_WIDTH-1:0] ld_sum_r;      // running row sum including this element
  logic [ROW_W-1:0]     ld_row_r;
  logic [COL_W-1:0]     ld_col_r;
  logic [ROW_W-1:0]     q_r1_r, q_r2_r;
  logic [COL_W-1:0]     q_c1_r;
  logic [1:0]           q_stat_r;
  logic [SUM_WIDTH-1:0] q_part_r;      // D(r2,c2) - D(r1-1,c2)

  // table memory
  logic [SUM_WIDTH-1:0] table_mem [DEPTH];
  logic [SUM_WIDTH-1:0] rd_a_r, rd_b_r;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr_a, rd_addr_b;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [SUM_WIDTH-1:0] wr_data;

  // output register
  logic                 out_valid_r;
  sat_out_t             out_data_r;
  logic                 out_free;
  logic                 done;
  sat_out_t             res;

  logic                 in_fire, cfg_fire, cfg_hit;
  logic                 wrap;
  logic [ROW_W-1:0]     pos_row;
  logic [COL_W-1:0]     pos_col;
  logic [SUM_WIDTH-1:0] row_base, elem_ext;
  logic [DIM_W-1:0]     col_inc, row_inc;
  logic [DIM_W-1:0]     r2_ext, c2_ext;
  logic [1:0]           q_stat_in;
  logic [SUM_WIDTH-1:0] above, c_term, d_term;

  assign rows_eff = clamp_dim(rows_cfg_r, MAX_ROWS_D);
  assign cols_eff = clamp_dim(cols_cfg_r, MAX_COLS_D);

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && ((cfg_index == CFG_ROWS) || (cfg_index == CFG_COLS));

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // load position seen by an incoming element; wraps if it fell outside the dims
  assign wrap     = ({1'b0, load_row_r} >= rows_eff) || ({1'b0, load_col_r} >= cols_eff);
  assign pos_row  = wrap ? '0 : load_row_r;
  assign pos_col  = wrap ? '0 : load_col_r;
  assign row_base = wrap ? '0 : row_sum_r;
  assign elem_ext = {{(SUM_WIDTH-ELEM_WIDTH){in_data.element_value[ELEM_WIDTH-1]}},
                     in_data.element_value};

  // query checks, not-loaded first
  assign r2_ext = {1'b0, in_data.row_final};
  assign c2_ext = {1'b0, in_data.col_final};
  always_comb begin
    if (!complete_r) begin
      q_stat_in = STAT_NOT_LOADED;
    end else if ((in_data.row_first > in_data.row_final) ||
                 (in_data.col_first > in_data.col_final) ||
                 (r2_ext >= rows_eff) || (c2_ext >= cols_eff)) begin
      q_stat_in = STAT_BAD_COORD;
    end else begin
      q_stat_in = STAT_OK;
    end
  end

  // read address selection
  always_comb begin
    rd_en     = 1'b0;
    rd_addr_a = '0;
    rd_addr_b = '0;
    case (state_r)
      ST_IDLE: begin
        rd_en = in_fire;
        if (in_data.mode == MODE_LOAD) begin
          rd_addr_a = {pos_row - ROW_W'(1), pos_col};
        end else begin
          rd_addr_a = {in_data.row_final, in_data.col_final};
          rd_addr_b = {in_data.row_first - ROW_W'(1), in_data.col_final};
        end
      end
      ST_QRD: begin
        rd_en     = 1'b1;
        rd_addr_a = {q_r2_r, q_c1_r - COL_W'(1)};
        rd_addr_b = {q_r1_r - ROW_W'(1), q_c1_r - COL_W'(1)};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // result of the finishing state; virtual zero row/column masked here
  assign above  = (ld_row_r == '0) ? '0 : rd_a_r;
  assign c_term = (q_c1_r == '0) ? '0 : rd_a_r;
  assign d_term = ((q_r1_r == '0) || (q_c1_r == '0)) ? '0 : rd_b_r;

  always_comb begin
    res.sum_value = '0;
    res.status    = STAT_OK;
    if (state_r == ST_LOAD) begin
      res.sum_value = ld_sum_r + above;
    end else if (q_stat_r == STAT_OK) begin
      res.sum_value = q_part_r - c_term + d_term;
    end else begin
      res.status = q_stat_r;
    end
  end

  assign done    = ((state_r == ST_LOAD) || (state_r == ST_QSUM)) && out_free;
  assign wr_en   = (state_r == ST_LOAD) && out_free;
  assign wr_addr = {ld_row_r, ld_col_r};
  assign wr_data = ld_sum_r + above;

  // next column / row counts of the element being finished
  assign col_inc = {1'b0, ld_col_r} + DIM_W'(1);
  assign row_inc = {1'b0, ld_row_r} + DIM_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = (in_data.mode == MODE_LOAD) ? ST_LOAD : ST_QRD;
      end
      ST_LOAD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_QRD: begin
        state_nxt = ST_QSUM;
      end
      ST_QSUM: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // table memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) table_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= table_mem[rd_addr_a];
      rd_b_r <= table_mem[rd_addr_b];
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ld_sum_r <= row_base + elem_ext;
      ld_row_r <= pos_row;
      ld_col_r <= pos_col;
      q_r1_r   <= in_data.row_first;
      q_c1_r   <= in_data.col_first;
      q_r2_r   <= in_data.row_final;
      q_stat_r <= q_stat_in;
    end
    if (state_r == ST_QRD) begin
      q_part_r <= rd_a_r - ((q_r1_r == '0) ? '0 : rd_b_r);
    end
    if (done) out_data_r <= res;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rows_cfg_r  <= MAX_ROWS_D;
      cols_cfg_r  <= MAX_COLS_D;
      row_sum_r   <= '0;
      load_row_r  <= '0;
      load_col_r  <= '0;
      complete_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (done) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (cfg_hit) begin
        // any dimension write restarts loading
        if (cfg_index == CFG_ROWS) rows_cfg_r <= cfg_data;
        else cols_cfg_r <= cfg_data;
        row_sum_r  <= '0;
        load_row_r <= '0;
        load_col_r <= '0;
        complete_r <= 1'b0;
      end else if (wr_en) begin
        if (col_inc >= cols_eff) begin
          load_col_r <= '0;
          row_sum_r  <= '0;
          if (row_inc >= rows_eff) begin
            load_row_r <= '0;
            complete_r <= 1'b1;
          end else begin
            load_row_r <= row_inc[ROW_W-1:0];
          end
        end else begin
          load_col_r <= col_inc[COL_W-1:0];
          load_row_r <= ld_row_r;
          row_sum_r  <= ld_sum_r;
        end
      end
    end
  end

endmodule
